@@ rtl/core/adrc_pkg.sv @@
// Shared types, codes and saturation helpers for the disturbance rejection controller.
package adrc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [2:0] CFG_STEP_SIZE   = 3'd0;
    localparam logic [2:0] CFG_TRACK_SPEED = 3'd1;
    localparam logic [2:0] CFG_OBSERVER_BW = 3'd2;
    localparam logic [2:0] CFG_PLANT_GAIN  = 3'd3;
    localparam logic [2:0] CFG_PROP_GAIN   = 3'd4;
    localparam logic [2:0] CFG_DERIV_GAIN  = 3'd5;
    localparam logic [2:0] CFG_SHAPE_MODE  = 3'd6;
    localparam logic [2:0] CFG_LINEAR_ZONE = 3'd7;

    localparam logic [16:0] RST_STEP_SIZE   = 17'd655;
    localparam logic [30:0] RST_TRACK_SPEED = 31'd65536;
    localparam logic [30:0] RST_PLANT_GAIN  = 31'd65536;
    localparam logic [30:0] RST_LINEAR_ZONE = 31'd65536;

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] measured;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] tracked_target;
        logic signed [31:0] disturbance_est;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef enum logic {
        IT_DIV,
        IT_SQRT
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_X1, ST_RH, ST_D, ST_A0, ST_Y, ST_T, ST_SQ1, ST_SQ1W, ST_HALF, ST_A2, ST_A,
        ST_FZ, ST_FDW, ST_FM, ST_FN, ST_TP, ST_HF, ST_TV,
        ST_B01A, ST_B01B, ST_W2, ST_B02A, ST_B02B, ST_B03,
        ST_E, ST_Z1A, ST_Z1B, ST_Z1C, ST_Z1D,
        ST_Z2A, ST_Z2B, ST_Z2C, ST_Z2D, ST_Z2E, ST_Z2F,
        ST_Z3A, ST_Z3B, ST_Z3C,
        ST_E1, ST_E2, ST_FAL, ST_G1W, ST_G2, ST_G2W,
        ST_KP, ST_KD, ST_U0, ST_DV, ST_DVW, ST_U, ST_OUT
    } t_step;

    typedef enum logic [4:0] {
        W_NONE, W_TMP, W_TMP2, W_D, W_A0, W_Y, W_AA, W_FH,
        W_B01, W_B02, W_B03, W_W2, W_E, W_E1, W_E2, W_DTERM, W_U0,
        W_TP, W_TV, W_OP, W_OV, W_OD, W_LD
    } t_dst;

    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return Q_MAX;
        if (v < lo) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [32:0] f_x33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

endpackage

@@ rtl/core/adrc_alu.sv @@
// Shared saturating add, subtract and fixed-point multiply unit.
module adrc_alu #(
    parameter int FRAC_BITS = adrc_pkg::FRAC_BITS_DEF
) (
    input  adrc_pkg::t_alu_op   i_op,
    input  logic signed [32:0]  i_a,
    input  logic signed [32:0]  i_b,
    output logic signed [31:0]  o_res,
    output logic [63:0]         o_prod
);
    import adrc_pkg::*;

    logic signed [65:0] w_prod;
    logic signed [65:0] w_shift;
    logic signed [33:0] w_sum;
    logic signed [33:0] w_dif;

    assign w_prod  = i_a * i_b;
    // arithmetic shift rounds toward minus infinity
    assign w_shift = w_prod >>> FRAC_BITS;
    assign w_sum   = {i_a[32], i_a} + {i_b[32], i_b};
    assign w_dif   = {i_a[32], i_a} - {i_b[32], i_b};
    assign o_prod  = w_prod[63:0];

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = f_sat(66'(w_sum));
            ALU_SUB: o_res = f_sat(66'(w_dif));
            ALU_MUL: o_res = f_sat(w_shift);
            default: o_res = '0;
        endcase
    end

endmodule

@@ rtl/core/adrc_iter.sv @@
// Iterative unit: restoring fixed-point divide and bit-pair integer square root.
module adrc_iter #(
    parameter int FRAC_BITS = adrc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adrc_pkg::t_iter_ctl i_ctl,
    input  logic signed [31:0]  i_num,
    input  logic [30:0]         i_den,
    input  logic [63:0]         i_rad,
    output adrc_pkg::t_iter_sts o_sts,
    output logic signed [31:0]  o_res
);
    import adrc_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int SQ_STEPS = 32;
    localparam logic [DW-1:0] Q_LIM_POS = DW'(33'h0_7FFF_FFFF);
    localparam logic [DW-1:0] Q_LIM_NEG = DW'(33'h0_8000_0000);

    logic            r_busy;
    logic            r_done;
    t_iter_op        r_op;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [DW-1:0]   r_dq;
    logic [31:0]     r_rem;
    logic [30:0]     r_den;
    logic [63:0]     r_x;
    logic [63:0]     r_r;
    logic [63:0]     r_bit;

    logic [32:0]     w_abs;
    logic [32:0]     w_rem2;
    logic [32:0]     w_diff;
    logic            w_ge;
    logic [63:0]     w_sum;
    logic            w_take;
    logic signed [31:0] w_qres;

    assign w_abs  = i_num[31] ? -f_x33(i_num) : f_x33(i_num);
    assign w_rem2 = {r_rem, r_dq[DW-1]};
    assign w_diff = w_rem2 - {2'b00, r_den};
    assign w_ge   = w_rem2 >= {2'b00, r_den};
    assign w_sum  = r_r + r_bit;
    assign w_take = r_x >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.op == IT_DIV) ? CW'(DW) : CW'(SQ_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_op  <= i_ctl.op;
            r_neg <= i_num[31];
            r_dq  <= {w_abs[31:0], {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_x   <= i_rad;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_op == IT_DIV) begin
                r_dq  <= {r_dq[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[31:0] : w_rem2[31:0];
            end else begin
                if (w_take) begin
                    r_x <= r_x - w_sum;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    // saturate the quotient magnitude back into signed range
    always_comb begin
        if (r_neg) begin
            w_qres = (r_dq > Q_LIM_NEG) ? Q_MIN : -$signed(r_dq[31:0]);
        end else begin
            w_qres = (r_dq > Q_LIM_POS) ? Q_MAX : $signed(r_dq[31:0]);
        end
    end

    assign o_res      = (r_op == IT_DIV) ? w_qres : $signed(r_r[31:0]);
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ rtl/core/adrc_controller_step.sv @@
// Top level: sequencer driving the shared ALU and iterative unit through one control tick.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  input    | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  output   | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One request runs a sequence of ALU steps, some of them optional, plus a wait on the
// serial root unit per square root and on the serial divider per divide: one to three roots
// and one or two divides.
// Reset is synchronous and clears state and configuration to defaults.
// A finished result sits in the output register while the next request is taken; a
// result that is still stalled holds the sequencer at its last step.
module adrc_controller_step #(
    parameter int FRAC_BITS = adrc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  adrc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output adrc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import adrc_pkg::*;

    // configuration
    logic [16:0]        r_h;
    logic [30:0]        r_r;
    logic [30:0]        r_w0;
    logic [30:0]        r_b;
    logic signed [31:0] r_kp;
    logic signed [31:0] r_kd;
    logic               r_mode;
    logic [30:0]        r_zone;

    // controller state
    logic signed [31:0] r_tp, r_tv, r_op, r_ov, r_od, r_ld;
    logic signed [31:0] r_tgt, r_meas;

    // scratch
    logic signed [31:0] r_tmp, r_tmp2, r_d, r_a0, r_y, r_aa, r_fh;
    logic signed [31:0] r_b01, r_b02, r_b03, r_w2, r_e, r_e1, r_e2, r_dterm, r_u0;

    t_step r_step, n_step;

    logic               r_out_valid;
    t_out_item          r_out;

    t_alu_op            w_op;
    logic signed [32:0] w_a, w_b;
    logic signed [31:0] w_alu;
    logic [63:0]        w_prod;
    t_dst               w_dst;
    logic signed [31:0] w_wdata;
    t_iter_ctl          w_ictl;
    logic signed [31:0] w_inum;
    logic [30:0]        w_iden;
    t_iter_sts          w_ists;
    logic signed [31:0] w_ires;

    logic [32:0]        w_ay;
    logic [36:0]        w_tsum;
    logic signed [31:0] w_tsat;
    logic signed [32:0] w_half;
    logic signed [32:0] w_nd;
    logic               w_y_zone, w_a_zone;
    logic [32:0]        w_e2abs;
    logic               w_out_free;
    logic               w_accept;

    adrc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_res  (w_alu),
        .o_prod (w_prod)
    );

    adrc_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ictl),
        .i_num   (w_inum),
        .i_den   (w_iden),
        .i_rad   (w_prod),
        .o_sts   (w_ists),
        .o_res   (w_ires)
    );

    assign o_in_stall = (r_step != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // differentiator side terms
    assign w_ay     = r_y[31] ? -f_x33(r_y) : f_x33(r_y);
    assign w_tsum   = {4'b0000, r_d[31:0]} + {1'b0, w_ay, 3'b000};
    assign w_tsat   = (w_tsum > 37'd2147483647) ? Q_MAX : $signed(w_tsum[31:0]);
    assign w_half   = (f_x33(r_tmp) - f_x33(r_d)) >>> 1;
    assign w_nd     = -f_x33(r_d);
    assign w_y_zone = (f_x33(r_y) >= w_nd) && (f_x33(r_y) < f_x33(r_d));
    assign w_a_zone = (f_x33(r_aa) >= w_nd) && (f_x33(r_aa) < f_x33(r_d));
    assign w_e2abs  = r_e2[31] ? -f_x33(r_e2) : f_x33(r_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        n_step  = r_step;
        w_op    = ALU_ADD;
        w_a     = '0;
        w_b     = '0;
        w_dst   = W_NONE;
        w_wdata = w_alu;
        w_ictl  = '{start: 1'b0, op: IT_DIV};
        w_inum  = r_aa;
        w_iden  = r_d[30:0];
        case (r_step)
            ST_IDLE: begin
                if (w_accept) n_step = ST_X1;
            end
            ST_X1: begin
                w_op = ALU_SUB; w_a = f_x33(r_tp); w_b = f_x33(r_tgt);
                w_dst = W_TMP; n_step = ST_RH;
            end
            ST_RH: begin
                w_op = ALU_MUL; w_a = {2'b00, r_r}; w_b = {16'd0, r_h};
                w_dst = W_D; n_step = ST_D;
            end
            ST_D: begin
                w_op = ALU_MUL; w_a = f_x33(r_d); w_b = {16'd0, r_h};
                w_dst = W_D; n_step = ST_A0;
            end
            ST_A0: begin
                w_op = ALU_MUL; w_a = {16'd0, r_h}; w_b = f_x33(r_tv);
                w_dst = W_A0; n_step = ST_Y;
            end
            ST_Y: begin
                w_op = ALU_ADD; w_a = f_x33(r_tmp); w_b = f_x33(r_a0);
                w_dst = W_Y; n_step = ST_T;
            end
            ST_T: begin
                w_dst = W_TMP; w_wdata = w_tsat; n_step = ST_SQ1;
            end
            ST_SQ1: begin
                w_op = ALU_MUL; w_a = f_x33(r_d); w_b = f_x33(r_tmp);
                w_ictl = '{start: 1'b1, op: IT_SQRT}; n_step = ST_SQ1W;
            end
            ST_SQ1W: begin
                if (w_ists.done) begin
                    w_dst = W_TMP; w_wdata = w_ires; n_step = ST_HALF;
                end
            end
            ST_HALF: begin
                w_dst = W_TMP2; w_wdata = w_half[31:0]; n_step = ST_A2;
            end
            ST_A2: begin
                w_op = r_y[31] ? ALU_SUB : ALU_ADD;
                w_a = f_x33(r_a0); w_b = f_x33(r_tmp2);
                w_dst = W_AA; n_step = ST_A;
            end
            ST_A: begin
                w_op = ALU_ADD; w_a = f_x33(r_a0); w_b = f_x33(r_y);
                if (w_y_zone) w_dst = W_AA;
                n_step = ST_FZ;
            end
            ST_FZ: begin
                if (w_a_zone) begin
                    w_ictl = '{start: 1'b1, op: IT_DIV}; n_step = ST_FDW;
                end else begin
                    // outside the zone: drive full speed against the sign of a
                    w_dst   = W_FH;
                    w_wdata = r_aa[31] ? $signed({1'b0, r_r}) : -$signed({1'b0, r_r});
                    n_step  = ST_TP;
                end
            end
            ST_FDW: begin
                if (w_ists.done) begin
                    w_dst = W_TMP; w_wdata = w_ires; n_step = ST_FM;
                end
            end
            ST_FM: begin
                w_op = ALU_MUL; w_a = {2'b00, r_r}; w_b = f_x33(r_tmp);
                w_dst = W_TMP; n_step = ST_FN;
            end
            ST_FN: begin
                w_op = ALU_SUB; w_a = '0; w_b = f_x33(r_tmp);
                w_dst = W_FH; n_step = ST_TP;
            end
            ST_TP: begin
                w_op = ALU_ADD; w_a = f_x33(r_tp); w_b = f_x33(r_a0);
                w_dst = W_TP; n_step = ST_HF;
            end
            ST_HF: begin
                w_op = ALU_MUL; w_a = {16'd0, r_h}; w_b = f_x33(r_fh);
                w_dst = W_TMP; n_step = ST_TV;
            end
            ST_TV: begin
                w_op = ALU_ADD; w_a = f_x33(r_tv); w_b = f_x33(r_tmp);
                w_dst = W_TV; n_step = ST_B01A;
            end
            ST_B01A: begin
                w_op = ALU_ADD; w_a = {2'b00, r_w0}; w_b = {2'b00, r_w0};
                w_dst = W_B01; n_step = ST_B01B;
            end
            ST_B01B: begin
                w_op = ALU_ADD; w_a = f_x33(r_b01); w_b = {2'b00, r_w0};
                w_dst = W_B01; n_step = ST_W2;
            end
            ST_W2: begin
                w_op = ALU_MUL; w_a = {2'b00, r_w0}; w_b = {2'b00, r_w0};
                w_dst = W_W2; n_step = ST_B02A;
            end
            ST_B02A: begin
                w_op = ALU_ADD; w_a = f_x33(r_w2); w_b = f_x33(r_w2);
                w_dst = W_B02; n_step = ST_B02B;
            end
            ST_B02B: begin
                w_op = ALU_ADD; w_a = f_x33(r_b02); w_b = f_x33(r_w2);
                w_dst = W_B02; n_step = ST_B03;
            end
            ST_B03: begin
                w_op = ALU_MUL; w_a = f_x33(r_w2); w_b = {2'b00, r_w0};
                w_dst = W_B03; n_step = ST_E;
            end
            ST_E: begin
                w_op = ALU_SUB; w_a = f_x33(r_op); w_b = f_x33(r_meas);
                w_dst = W_E; n_step = ST_Z1A;
            end
            ST_Z1A: begin
                w_op = ALU_MUL; w_a = f_x33(r_b01); w_b = f_x33(r_e);
                w_dst = W_TMP; n_step = ST_Z1B;
            end
            ST_Z1B: begin
                w_op = ALU_SUB; w_a = f_x33(r_ov); w_b = f_x33(r_tmp);
                w_dst = W_TMP; n_step = ST_Z1C;
            end
            ST_Z1C: begin
                w_op = ALU_MUL; w_a = {16'd0, r_h}; w_b = f_x33(r_tmp);
                w_dst = W_TMP; n_step = ST_Z1D;
            end
            ST_Z1D: begin
                w_op = ALU_ADD; w_a = f_x33(r_op); w_b = f_x33(r_tmp);
                w_dst = W_OP; n_step = ST_Z2A;
            end
            ST_Z2A: begin
                w_op = ALU_MUL; w_a = f_x33(r_b02); w_b = f_x33(r_e);
                w_dst = W_TMP; n_step = ST_Z2B;
            end
            ST_Z2B: begin
                w_op = ALU_SUB; w_a = f_x33(r_od); w_b = f_x33(r_tmp);
                w_dst = W_TMP; n_step = ST_Z2C;
            end
            ST_Z2C: begin
                w_op = ALU_MUL; w_a = {2'b00, r_b}; w_b = f_x33(r_ld);
                w_dst = W_TMP2; n_step = ST_Z2D;
            end
            ST_Z2D: begin
                w_op = ALU_ADD; w_a = f_x33(r_tmp); w_b = f_x33(r_tmp2);
                w_dst = W_TMP; n_step = ST_Z2E;
            end
            ST_Z2E: begin
                w_op = ALU_MUL; w_a = {16'd0, r_h}; w_b = f_x33(r_tmp);
                w_dst = W_TMP; n_step = ST_Z2F;
            end
            ST_Z2F: begin
                w_op = ALU_ADD; w_a = f_x33(r_ov); w_b = f_x33(r_tmp);
                w_dst = W_OV; n_step = ST_Z3A;
            end
            ST_Z3A: begin
                w_op = ALU_MUL; w_a = {16'd0, r_h}; w_b = f_x33(r_b03);
                w_dst = W_TMP; n_step = ST_Z3B;
            end
            ST_Z3B: begin
                w_op = ALU_MUL; w_a = f_x33(r_tmp); w_b = f_x33(r_e);
                w_dst = W_TMP; n_step = ST_Z3C;
            end
            ST_Z3C: begin
                w_op = ALU_SUB; w_a = f_x33(r_od); w_b = f_x33(r_tmp);
                w_dst = W_OD; n_step = ST_E1;
            end
            ST_E1: begin
                w_op = ALU_SUB; w_a = f_x33(r_tp); w_b = f_x33(r_op);
                w_dst = W_E1; n_step = ST_E2;
            end
            ST_E2: begin
                w_op = ALU_SUB; w_a = f_x33(r_tv); w_b = f_x33(r_ov);
                w_dst = W_E2; n_step = ST_FAL;
            end
            ST_FAL: begin
                w_op = ALU_MUL; w_a = $signed(w_e2abs); w_b = {2'b00, r_zone};
                if (r_mode && (w_e2abs >= {2'b00, r_zone})) begin
                    w_ictl = '{start: 1'b1, op: IT_SQRT}; n_step = ST_G1W;
                end else begin
                    w_dst = W_DTERM; w_wdata = r_e2; n_step = ST_KP;
                end
            end
            ST_G1W: begin
                if (w_ists.done) begin
                    w_dst = W_TMP; w_wdata = w_ires; n_step = ST_G2;
                end
            end
            ST_G2: begin
                w_op = ALU_MUL; w_a = f_x33(r_tmp); w_b = {2'b00, r_zone};
                w_ictl = '{start: 1'b1, op: IT_SQRT}; n_step = ST_G2W;
            end
            ST_G2W: begin
                if (w_ists.done) begin
                    w_dst   = W_DTERM;
                    w_wdata = r_e2[31] ? -w_ires : w_ires;
                    n_step  = ST_KP;
                end
            end
            ST_KP: begin
                w_op = ALU_MUL; w_a = f_x33(r_kp); w_b = f_x33(r_e1);
                w_dst = W_TMP; n_step = ST_KD;
            end
            ST_KD: begin
                w_op = ALU_MUL; w_a = f_x33(r_kd); w_b = f_x33(r_dterm);
                w_dst = W_TMP2; n_step = ST_U0;
            end
            ST_U0: begin
                w_op = ALU_ADD; w_a = f_x33(r_tmp); w_b = f_x33(r_tmp2);
                w_dst = W_U0; n_step = ST_DV;
            end
            ST_DV: begin
                // zero plant gain saturates by the sign of the dividend in the divider
                w_inum = r_od; w_iden = r_b;
                w_ictl = '{start: 1'b1, op: IT_DIV}; n_step = ST_DVW;
            end
            ST_DVW: begin
                if (w_ists.done) begin
                    w_dst = W_TMP; w_wdata = w_ires; n_step = ST_U;
                end
            end
            ST_U: begin
                w_op = ALU_SUB; w_a = f_x33(r_u0); w_b = f_x33(r_tmp);
                w_dst = W_LD; n_step = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) n_step = ST_IDLE;
            end
            default: n_step = ST_IDLE;
        endcase
    end

    // controller state and scratch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= '0; r_tv <= '0; r_op <= '0;
            r_ov <= '0; r_od <= '0; r_ld <= '0;
        end else begin
            case (w_dst)
                W_TP:    r_tp <= w_wdata;
                W_TV:    r_tv <= w_wdata;
                W_OP:    r_op <= w_wdata;
                W_OV:    r_ov <= w_wdata;
                W_OD:    r_od <= w_wdata;
                W_LD:    r_ld <= w_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tgt  <= i_in_data.target;
            r_meas <= i_in_data.measured;
        end
        case (w_dst)
            W_TMP:   r_tmp   <= w_wdata;
            W_TMP2:  r_tmp2  <= w_wdata;
            W_D:     r_d     <= w_wdata;
            W_A0:    r_a0    <= w_wdata;
            W_Y:     r_y     <= w_wdata;
            W_AA:    r_aa    <= w_wdata;
            W_FH:    r_fh    <= w_wdata;
            W_B01:   r_b01   <= w_wdata;
            W_B02:   r_b02   <= w_wdata;
            W_B03:   r_b03   <= w_wdata;
            W_W2:    r_w2    <= w_wdata;
            W_E:     r_e     <= w_wdata;
            W_E1:    r_e1    <= w_wdata;
            W_E2:    r_e2    <= w_wdata;
            W_DTERM: r_dterm <= w_wdata;
            W_U0:    r_u0    <= w_wdata;
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h    <= RST_STEP_SIZE;
            r_r    <= RST_TRACK_SPEED;
            r_w0   <= '0;
            r_b    <= RST_PLANT_GAIN;
            r_kp   <= '0;
            r_kd   <= '0;
            r_mode <= 1'b0;
            r_zone <= RST_LINEAR_ZONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_SIZE:   r_h    <= i_cfg_data[16:0];
                CFG_TRACK_SPEED: r_r    <= i_cfg_data[30:0];
                CFG_OBSERVER_BW: r_w0   <= i_cfg_data[30:0];
                CFG_PLANT_GAIN:  r_b    <= i_cfg_data[30:0];
                CFG_PROP_GAIN:   r_kp   <= $signed(i_cfg_data);
                CFG_DERIV_GAIN:  r_kd   <= $signed(i_cfg_data);
                CFG_SHAPE_MODE:  r_mode <= i_cfg_data[0];
                CFG_LINEAR_ZONE: r_zone <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // result register: hold while stalled, load on the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_step == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == ST_OUT && w_out_free) begin
            r_out.drive           <= r_ld;
            r_out.tracked_target  <= r_tp;
            r_out.disturbance_est <= r_od;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_rise_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_step == ST_OUT))
        else $error("result appeared outside the final step");

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ictl.start |-> !w_ists.busy)
        else $error("iterative unit started while busy");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_step == ST_X1))
        else $error("accepted request did not start the sequence");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ists.done |-> (r_step == ST_SQ1W || r_step == ST_FDW || r_step == ST_G1W
                         || r_step == ST_G2W || r_step == ST_DVW))
        else $error("iterative result arrived with no step waiting");

endmodule
